### rtl/tcw_pkg.sv
// shared types and constants for the text console writer
`default_nettype none

package tcw_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_RESULT
  } state_t;

  // cursor update request from the control sequencer
  typedef struct packed {
    logic put;
    logic home;
  } cur_cmd_t;

  // what the pending put does to the store
  typedef struct packed {
    logic printable;
    logic scroll;
  } cur_stat_t;

  localparam logic [7:0]  CHAR_BS      = 8'h08;
  localparam logic [7:0]  CHAR_TAB     = 8'h09;
  localparam logic [7:0]  CHAR_LF      = 8'h0A;
  localparam logic [7:0]  CHAR_CR      = 8'h0D;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;
  localparam logic [7:0]  ATTR_DEFAULT = 8'h0F;
  localparam logic [15:0] BLANK_CELL   = {ATTR_DEFAULT, CHAR_SPACE};

  localparam int POS_W  = 11;
  localparam int COL_OW = 7;
  localparam int ROW_OW = 5;
  localparam int WORD_W = 16;

endpackage

`default_nettype wire

### rtl/tcw_frame_ram.sv
// frame store: one write port, one registered read port
`default_nettype none

module tcw_frame_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wa,
  input  wire logic [DW-1:0] wd,
  input  wire logic [AW-1:0] ra,
  output logic      [DW-1:0] rd
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

### rtl/tcw_cursor.sv
// cursor registers and control-code interpretation for put
`default_nettype none

module tcw_cursor #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8,
  parameter int CW       = 7,
  parameter int RW       = 5,
  parameter int AW       = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tcw_pkg::cur_cmd_t cmd,
  input  wire logic [7:0]       char_code,
  output logic      [CW-1:0]    column,
  output logic      [RW-1:0]    row,
  output logic      [AW-1:0]    cell_addr,
  output tcw_pkg::cur_stat_t    stat
);

  logic [AW-1:0] row_base;
  logic [CW:0]   col_w;
  logic          row_adv;
  logic [CW:0]   tab_next [COLUMNS];

  // next tab stop per column, saturated at COLUMNS to mark a wrap
  for (genvar c = 0; c < COLUMNS; c++) begin : g_tab
    localparam int NT = ((c / TAB_STOP) + 1) * TAB_STOP;
    assign tab_next[c] = (CW + 1)'((NT < COLUMNS) ? NT : COLUMNS);
  end

  assign cell_addr = row_base + AW'(column);

  always_comb begin
    col_w          = {1'b0, column};
    row_adv        = 1'b0;
    stat.printable = 1'b0;
    case (char_code)
      tcw_pkg::CHAR_BS: begin
        if (column != '0) begin
          col_w = col_w - 1'b1;
        end
      end
      tcw_pkg::CHAR_TAB: begin
        col_w = tab_next[column];
      end
      tcw_pkg::CHAR_CR: begin
        col_w = '0;
      end
      tcw_pkg::CHAR_LF: begin
        col_w   = '0;
        row_adv = 1'b1;
      end
      default: begin
        // bytes with the top bit set count as negative and are ignored
        if (!char_code[7] && char_code >= tcw_pkg::CHAR_SPACE) begin
          stat.printable = 1'b1;
          col_w          = col_w + 1'b1;
        end
      end
    endcase
    if (col_w >= (CW + 1)'(COLUMNS)) begin
      col_w   = '0;
      row_adv = 1'b1;
    end
    stat.scroll = row_adv && (row == RW'(ROWS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.home) begin
      column   <= '0;
      row      <= '0;
      row_base <= '0;
    end else if (cmd.put) begin
      column <= col_w[CW-1:0];
      if (row_adv && !stat.scroll) begin
        row      <= row + 1'b1;
        row_base <= row_base + AW'(COLUMNS);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/text_console_writer.sv
// text console writer: command sequencer around the frame store
// sequence: put and unused command pass from accept to the result state, read through ST_READ;
//   clear blanks the whole store, a put that scrolls moves rows up, then blanks the last row
// throughput: one transaction at a time; scroll and clear walk the store
//   one cell per cycle through its single write port
// reset: the store is swept to blank with in_ready low
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  char_code,
  input  wire logic [10:0] cell_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [10:0]      cursor_position,
  output logic [6:0]       cursor_column,
  output logic [4:0]       cursor_row,
  output logic             scrolled,
  output logic [15:0]      cell_word
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = (AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W;
  localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

  tcw_pkg::state_t   state, state_next;
  tcw_pkg::cmd_t     cmd;
  tcw_pkg::cur_cmd_t cur_cmd;
  tcw_pkg::cur_stat_t cur_stat;

  logic [7:0]    attr;
  logic [AW-1:0] ptr;
  logic          copy_valid;
  logic [AW-1:0] copy_dst;
  logic          report;
  logic          pend_scrolled;
  logic          pend_hit;
  logic          pend_read;
  logic [15:0]   pend_word;

  logic [CW-1:0] column;
  logic [RW-1:0] row;
  logic [AW-1:0] cell_addr;

  logic          accept;
  logic          out_free;
  logic [IW-1:0] cell_ext;
  logic          read_hit;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic [AW-1:0] mem_ra;
  logic [15:0]   mem_rd;

  logic [31:0]   pos_wide;
  logic [31:0]   row_wide;

  assign cmd      = tcw_pkg::cmd_t'(command);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cell_ext = IW'(cell_index);
  assign read_hit = cell_ext < IW'(CELLS);
  assign pos_wide = 32'(cell_addr);
  assign row_wide = 32'(row);

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP),
    .CW      (CW),
    .RW      (RW),
    .AW      (AW)
  ) u_cursor (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cur_cmd),
    .char_code(char_code),
    .column   (column),
    .row      (row),
    .cell_addr(cell_addr),
    .stat     (cur_stat)
  );

  tcw_frame_ram #(
    .DEPTH(CELLS),
    .AW   (AW),
    .DW   (tcw_pkg::WORD_W)
  ) u_ram (
    .clk(clk),
    .we (mem_we),
    .wa (mem_wa),
    .wd (mem_wd),
    .ra (mem_ra),
    .rd (mem_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_FILL: begin
        if (!copy_valid && ptr == LAST) begin
          state_next = report ? tcw_pkg::ST_RESULT : tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd)
            tcw_pkg::CMD_PUT:
              state_next = cur_stat.scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_RESULT;
            tcw_pkg::CMD_CLEAR: state_next = tcw_pkg::ST_FILL;
            tcw_pkg::CMD_READ:  state_next = tcw_pkg::ST_READ;
            default:            state_next = tcw_pkg::ST_RESULT;
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        state_next = tcw_pkg::ST_RESULT;
      end
      tcw_pkg::ST_SCROLL: begin
        if (ptr == LAST) begin
          state_next = tcw_pkg::ST_FILL;
        end
      end
      tcw_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake, cursor request and store ports
  always_comb begin
    in_ready     = (state == tcw_pkg::ST_IDLE);
    cur_cmd.put  = accept && (cmd == tcw_pkg::CMD_PUT);
    cur_cmd.home = accept && (cmd == tcw_pkg::CMD_CLEAR);
    mem_ra       = (state == tcw_pkg::ST_SCROLL) ? ptr : cell_ext[AW-1:0];
    mem_we       = 1'b0;
    mem_wa       = cell_addr;
    mem_wd       = {attr, char_code};
    if (copy_valid) begin
      // a row-move write wins the port over the blanking sweep
      mem_we = 1'b1;
      mem_wa = copy_dst;
      mem_wd = mem_rd;
    end else if (state == tcw_pkg::ST_FILL) begin
      mem_we = 1'b1;
      mem_wa = ptr;
      mem_wd = tcw_pkg::BLANK_CELL;
    end else if (cur_cmd.put && cur_stat.printable) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcw_pkg::ST_FILL;
      ptr        <= '0;
      copy_valid <= 1'b0;
      report     <= 1'b0;
      attr       <= 8'd15;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      copy_valid <= (state == tcw_pkg::ST_SCROLL);
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      unique case (state)
        tcw_pkg::ST_IDLE: begin
          if (accept) begin
            report <= 1'b1;
            if (cmd == tcw_pkg::CMD_CLEAR) begin
              ptr <= '0;
            end else begin
              ptr <= AW'(COLUMNS);
            end
          end
        end
        tcw_pkg::ST_SCROLL: begin
          ptr <= (ptr == LAST) ? AW'(CELLS - COLUMNS) : ptr + 1'b1;
        end
        tcw_pkg::ST_FILL: begin
          if (!copy_valid && ptr != LAST) begin
            ptr <= ptr + 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (state == tcw_pkg::ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    copy_dst <= ptr - AW'(COLUMNS);
    if (accept) begin
      pend_scrolled <= (cmd == tcw_pkg::CMD_PUT) && cur_stat.scroll;
      pend_read     <= (cmd == tcw_pkg::CMD_READ);
      pend_hit      <= read_hit;
      pend_word     <= '0;
    end
    if (state == tcw_pkg::ST_READ) begin
      pend_word <= (pend_read && pend_hit) ? mem_rd : '0;
    end
    if (state == tcw_pkg::ST_RESULT && out_free) begin
      cursor_position <= pos_wide[tcw_pkg::POS_W-1:0];
      cursor_column   <= tcw_pkg::COL_OW'(column);
      cursor_row      <= row_wide[tcw_pkg::ROW_OW-1:0];
      scrolled        <= pend_scrolled;
      cell_word       <= pend_word;
    end
  end

endmodule

`default_nettype wire
